FILE: rtl/tmtw_pkg.sv
// ============================================================================
// tmtw_pkg: shared definitions for the text mode terminal writer
// Screen geometry, character codes, register indexes, controller states and
// the ANSI to VGA color map.
// ============================================================================
`default_nettype none

package tmtw_pkg;

   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int CELLS    = ROWS * COLUMNS;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int CELL_W   = 16;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int COLOR_W  = 3;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 3;

   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'd0;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'd32;
   localparam logic [CHAR_W-1:0] PRINT_LO     = 8'd32;
   localparam logic [CHAR_W-1:0] PRINT_HI     = 8'd126;
   localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0220;

   localparam logic [COLOR_W-1:0] FG_COLOR_RESET = 3'd2;
   localparam logic [COLOR_W-1:0] BG_COLOR_RESET = 3'd0;

   typedef enum logic {
      ACT_PUT  = 1'b0,
      ACT_READ = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FG_COLOR  = 2'd0,
      CSR_FG_BRIGHT = 2'd1,
      CSR_BG_COLOR  = 2'd2,
      CSR_BG_BRIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_FILL
   } ctrl_state_type;

   // VGA palette order swaps red with blue and yellow with cyan.
   function automatic logic [COLOR_W-1:0] ansi_to_vga(input logic [COLOR_W-1:0] ansi);
      logic [COLOR_W-1:0] vga;
      case (ansi)
         3'd1:    vga = 3'd4;
         3'd3:    vga = 3'd6;
         3'd4:    vga = 3'd1;
         3'd6:    vga = 3'd3;
         default: vga = ansi;
      endcase
      return vga;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/text_mode_terminal_writer_top.sv
// ============================================================================
// text_mode_terminal_writer_top: text screen writer with scroll
// Holds the color registers and the attribute, the screen RAM and the
// command controller.
// ============================================================================
// A put is answered in the cycle after its transfer; a read is answered through
// the screen RAM read register and then the response register. A put that does
// not scroll leaves busy low; a read keeps busy high in ST_READ. A put that
// scrolls keeps busy high for one pass over the screen RAM copying rows up, then
// the bottom row is blanked. After reset busy is high while the RAM is cleared.
// ============================================================================
`default_nettype none

module text_mode_terminal_writer_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_action,
   input  wire logic [tmtw_pkg::CHAR_W-1:0]      req_char_code,
   input  wire logic [tmtw_pkg::ROW_W-1:0]       req_read_row,
   input  wire logic [tmtw_pkg::COL_W-1:0]       req_read_col,
   output logic                                  rsp_valid,
   output logic [tmtw_pkg::CELL_W-1:0]           rsp_cell_value,
   output logic [tmtw_pkg::COL_W-1:0]            rsp_cursor_col,
   output logic [tmtw_pkg::ROW_W-1:0]            rsp_cursor_row,
   output logic                                  rsp_scrolled,
   input  wire logic                             csr_we,
   input  wire logic [tmtw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tmtw_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import tmtw_pkg::*;

   logic [COLOR_W-1:0] fg_color_ff;
   logic               fg_bright_ff;
   logic [COLOR_W-1:0] bg_color_ff;
   logic               bg_bright_ff;
   logic [ATTR_W-1:0]  attr;

   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [CELL_W-1:0]  mem_wr_data;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [CELL_W-1:0]  mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff  <= FG_COLOR_RESET;
         fg_bright_ff <= 1'b0;
         bg_color_ff  <= BG_COLOR_RESET;
         bg_bright_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FG_COLOR:  fg_color_ff  <= csr_wdata;
            CSR_FG_BRIGHT: fg_bright_ff <= csr_wdata[0];
            CSR_BG_COLOR:  bg_color_ff  <= csr_wdata;
            CSR_BG_BRIGHT: bg_bright_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign attr = {bg_bright_ff, ansi_to_vga(bg_color_ff),
                  fg_bright_ff, ansi_to_vga(fg_color_ff)};

   tmtw_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .attr           (attr),
      .rsp_valid      (rsp_valid),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_scrolled   (rsp_scrolled),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   tmtw_screen_ram #(
      .DATA_W (CELL_W),
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

FILE: rtl/tmtw_screen_ram.sv
// ============================================================================
// tmtw_screen_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ============================================================================
`default_nettype none

module tmtw_screen_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tmtw_ctrl.sv
// ============================================================================
// tmtw_ctrl: cursor, command sequencer and screen sweeps
// Handles put and read commands, the clearing sweep after reset and the
// scroll, which copies every row up by one and then blanks the bottom row.
// ============================================================================
`default_nettype none

module tmtw_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_action,
   input  wire logic [tmtw_pkg::CHAR_W-1:0]    req_char_code,
   input  wire logic [tmtw_pkg::ROW_W-1:0]     req_read_row,
   input  wire logic [tmtw_pkg::COL_W-1:0]     req_read_col,
   input  wire logic [tmtw_pkg::ATTR_W-1:0]    attr,
   output logic                                rsp_valid,
   output logic [tmtw_pkg::CELL_W-1:0]         rsp_cell_value,
   output logic [tmtw_pkg::COL_W-1:0]          rsp_cursor_col,
   output logic [tmtw_pkg::ROW_W-1:0]          rsp_cursor_row,
   output logic                                rsp_scrolled,
   output logic                                mem_wr_en,
   output logic [tmtw_pkg::ADDR_W-1:0]         mem_wr_addr,
   output logic [tmtw_pkg::CELL_W-1:0]         mem_wr_data,
   output logic                                mem_rd_en,
   output logic [tmtw_pkg::ADDR_W-1:0]         mem_rd_addr,
   input  wire logic [tmtw_pkg::CELL_W-1:0]    mem_rd_data
);

   import tmtw_pkg::*;

   ctrl_state_type     state_ff, state_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [ADDR_W-1:0]  dst_ff, dst_in;
   logic               copy_vld_ff, copy_vld_in;
   logic               read_ok_ff, read_ok_in;
   logic [COL_W-1:0]   cursor_x_ff, cursor_x_in;
   logic [ROW_W-1:0]   cursor_y_ff, cursor_y_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]  rsp_cell_ff, rsp_cell_in;
   logic [COL_W-1:0]   rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic               rsp_scrolled_ff, rsp_scrolled_in;

   logic [ADDR_W-1:0]  cursor_addr;
   logic [ADDR_W-1:0]  read_addr;
   logic [COL_W:0]     x_next;
   logic               accept;
   logic               last_sweep;

   assign accept      = start && (state_ff == ST_IDLE);
   assign cursor_addr = ADDR_W'(cursor_y_ff) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_x_ff);
   assign read_addr   = ADDR_W'(req_read_row) * ADDR_W'(COLUMNS) + ADDR_W'(req_read_col);
   assign x_next      = {1'b0, cursor_x_ff} + (COL_W+1)'(1);
   assign last_sweep  = (sweep_ff == ADDR_W'(CELLS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         sweep_ff        <= '0;
         copy_vld_ff     <= 1'b0;
         cursor_x_ff     <= '0;
         cursor_y_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sweep_ff        <= sweep_in;
         copy_vld_ff     <= copy_vld_in;
         cursor_x_ff     <= cursor_x_in;
         cursor_y_ff     <= cursor_y_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_ff          <= dst_in;
      read_ok_ff      <= read_ok_in;
      rsp_cell_ff     <= rsp_cell_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   always_comb begin
      state_in        = state_ff;
      sweep_in        = sweep_ff;
      dst_in          = dst_ff;
      copy_vld_in     = 1'b0;
      read_ok_in      = read_ok_ff;
      cursor_x_in     = cursor_x_ff;
      cursor_y_in     = cursor_y_ff;
      rsp_valid_in    = 1'b0;
      rsp_cell_in     = rsp_cell_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = sweep_ff;
      mem_wr_data     = RESET_CELL;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = sweep_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            if (last_sweep) begin
               state_in = ST_IDLE;
               sweep_in = '0;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end

         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_READ) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = read_addr;
                  read_ok_in  = ({1'b0, req_read_row} < (ROW_W+1)'(ROWS)) &&
                                ({1'b0, req_read_col} < (COL_W+1)'(COLUMNS));
                  state_in    = ST_READ;
               end else begin
                  // A put is answered right away; a scroll runs afterwards.
                  rsp_valid_in    = 1'b1;
                  rsp_cell_in     = '0;
                  rsp_scrolled_in = 1'b0;
                  rsp_col_in      = cursor_x_ff;
                  rsp_row_in      = cursor_y_ff;
                  if (req_char_code != CHAR_NUL) begin
                     if ((req_char_code >= PRINT_LO) && (req_char_code <= PRINT_HI)) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = cursor_addr;
                        mem_wr_data = {attr, req_char_code};
                     end
                     if ((x_next >= (COL_W+1)'(COLUMNS)) || (req_char_code == CHAR_NEWLINE)) begin
                        cursor_x_in = '0;
                        rsp_col_in  = '0;
                        if (cursor_y_ff == ROW_W'(ROWS - 1)) begin
                           rsp_scrolled_in = 1'b1;
                           sweep_in        = ADDR_W'(COLUMNS);
                           state_in        = ST_SCROLL;
                        end else begin
                           cursor_y_in = cursor_y_ff + ROW_W'(1);
                           rsp_row_in  = cursor_y_ff + ROW_W'(1);
                        end
                     end else begin
                        cursor_x_in = x_next[COL_W-1:0];
                        rsp_col_in  = x_next[COL_W-1:0];
                     end
                  end
               end
            end
         end

         ST_READ: begin
            rsp_valid_in    = 1'b1;
            rsp_cell_in     = read_ok_ff ? mem_rd_data : '0;
            rsp_col_in      = cursor_x_ff;
            rsp_row_in      = cursor_y_ff;
            rsp_scrolled_in = 1'b0;
            state_in        = ST_IDLE;
         end

         ST_SCROLL: begin
            // Read one row ahead; the data lands in the next cycle one row up.
            mem_rd_en   = 1'b1;
            copy_vld_in = 1'b1;
            dst_in      = sweep_ff - ADDR_W'(COLUMNS);
            if (copy_vld_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = dst_ff;
               mem_wr_data = mem_rd_data;
            end
            if (last_sweep) begin
               state_in = ST_FILL;
               sweep_in = ADDR_W'(CELLS - COLUMNS);
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end

         ST_FILL: begin
            mem_wr_en = 1'b1;
            if (copy_vld_ff) begin
               // The last copied cell still owns the write port this cycle.
               mem_wr_addr = dst_ff;
               mem_wr_data = mem_rd_data;
            end else begin
               mem_wr_data = {attr, CHAR_BLANK};
               if (last_sweep) begin
                  state_in = ST_IDLE;
                  sweep_in = '0;
               end else begin
                  sweep_in = sweep_ff + ADDR_W'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (cursor_x_ff < COL_W'(COLUMNS)) && (cursor_y_ff < ROW_W'(ROWS)))
      else $error("cursor left the screen");

   a_put_answered: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_PUT)) |=> rsp_valid_ff)
      else $error("put transfer without a response");

   a_read_answered: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_READ)) |-> ##2 rsp_valid_ff)
      else $error("read transfer without a response");

   a_scroll_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_scrolled_ff) |-> (state_ff == ST_SCROLL))
      else $error("scroll reported but no copy sweep running");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
      else $error("read and write of the same cell in one cycle");

endmodule

`default_nettype wire

FILE: sim/text_mode_terminal_writer_top_tb.sv
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_top_tb: self-checking bench for the terminal writer
// A screen shadow tracks the cell store, cursor and color registers, predicts
// the response to every accepted command and compares each response field by
// field. Stimulus runs a directed opening, then random text lines, reads and
// noise under four color settings, with sender gaps that change per phase.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tmtw_pkg::*;

   typedef struct packed {
      logic [CELL_W-1:0] cell_value;
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic              scrolled;
   } cursor_report_type;

   class screen_shadow;
      logic [CELL_W-1:0]  cells [CELLS];
      logic [COLOR_W-1:0] vga_of [8];
      int unsigned        cur_x;
      int unsigned        cur_y;
      logic [COLOR_W-1:0] fg_color;
      logic [COLOR_W-1:0] bg_color;
      logic               fg_bright;
      logic               bg_bright;
      cursor_report_type  awaited [$];
      int unsigned        errors;

      function new();
         // Palette order swaps red with blue and yellow with cyan.
         vga_of = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
         foreach (cells[i]) cells[i] = RESET_CELL;
         cur_x = 0;
         cur_y = 0;
         fg_color = FG_COLOR_RESET;
         bg_color = BG_COLOR_RESET;
         fg_bright = 1'b0;
         bg_bright = 1'b0;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_FG_COLOR:  fg_color  = value;
            CSR_FG_BRIGHT: fg_bright = value[0];
            CSR_BG_COLOR:  bg_color  = value;
            CSR_BG_BRIGHT: bg_bright = value[0];
            default: begin
            end
         endcase
      endfunction

      function logic [ATTR_W-1:0] attribute();
         return {bg_bright, vga_of[bg_color], fg_bright, vga_of[fg_color]};
      endfunction

      function void note_command(action_type act, logic [CHAR_W-1:0] ch,
                                 logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
         cursor_report_type rep;
         rep = '0;
         if (act == ACT_READ) begin
            if (row < ROWS && col < COLUMNS) rep.cell_value = cells[row * COLUMNS + col];
         end else if (ch != CHAR_NUL) begin
            if (ch >= PRINT_LO && ch <= PRINT_HI)
               cells[cur_y * COLUMNS + cur_x] = {attribute(), ch};
            // Every nonzero byte steps the column, a newline included.
            cur_x++;
            if (cur_x >= COLUMNS || ch == CHAR_NEWLINE) begin
               cur_x = 0;
               cur_y++;
               if (cur_y >= ROWS) begin
                  for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
                  for (int i = CELLS - COLUMNS; i < CELLS; i++)
                     cells[i] = {attribute(), CHAR_BLANK};
                  cur_y = ROWS - 1;
                  rep.scrolled = 1'b1;
               end
            end
         end
         rep.cursor_col = COL_W'(cur_x);
         rep.cursor_row = ROW_W'(cur_y);
         awaited.push_back(rep);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_report(cursor_report_type got);
         cursor_report_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            return;
         end
         want = awaited.pop_front();
         compare_field("cell_value", 32'(want.cell_value), 32'(got.cell_value));
         compare_field("cursor_col", 32'(want.cursor_col), 32'(got.cursor_col));
         compare_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
         compare_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   action_type           req_action = ACT_PUT;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic [ROW_W-1:0]     req_read_row = '0;
   logic [COL_W-1:0]     req_read_col = '0;
   logic                 rsp_valid;
   logic [CELL_W-1:0]    rsp_cell_value;
   logic [COL_W-1:0]     rsp_cursor_col;
   logic [ROW_W-1:0]     rsp_cursor_row;
   logic                 rsp_scrolled;
   logic                 csr_we = 1'b0;
   csr_index_type        csr_index = CSR_FG_COLOR;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   screen_shadow shadow = new();
   int unsigned  idle_pct = 0;

   text_mode_terminal_writer_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_scrolled   (rsp_scrolled),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         shadow.check_report({rsp_cell_value, rsp_cursor_col, rsp_cursor_row, rsp_scrolled});
   end

   // Holds start until the transfer edge; start stays high for a following command.
   task automatic send_item(input action_type act, input logic [CHAR_W-1:0] ch,
                            input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_char_code <= ch;
      req_read_row <= row;
      req_read_col <= col;
      @(posedge clock);
      while (busy) @(posedge clock);
      shadow.note_command(act, ch, row, col);
   endtask

   task automatic put_char(input logic [CHAR_W-1:0] ch);
      send_item(ACT_PUT, ch, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
   endtask

   task automatic read_cell(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
      send_item(ACT_READ, CHAR_W'($urandom_range(0, 255)), row, col);
   endtask

   // Mostly reads near the cursor, where fresh text sits; some fall off the screen.
   task automatic read_random();
      int unsigned pick;
      int          row;
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
         row = int'(shadow.cur_y) - int'($urandom_range(0, 2));
         if (row < 0) row = 0;
         read_cell(ROW_W'(row), COL_W'($urandom_range(0, COLUMNS - 1)));
      end else if (pick < 17) begin
         read_cell(ROW_W'($urandom_range(0, ROWS - 1)),
                   COL_W'($urandom_range(0, COLUMNS - 1)));
      end else begin
         read_cell(ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (shadow.awaited.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      shadow.set_reg(idx, value);
   endtask

   // Upper data bits of the bright registers are random; only bit 0 counts.
   task automatic set_colors(input logic [COLOR_W-1:0] fg, input logic fgb,
                             input logic [COLOR_W-1:0] bg, input logic bgb);
      write_reg(CSR_FG_COLOR, fg);
      write_reg(CSR_FG_BRIGHT, {2'($urandom_range(0, 3)), fgb});
      write_reg(CSR_BG_COLOR, bg);
      write_reg(CSR_BG_BRIGHT, {2'($urandom_range(0, 3)), bgb});
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(input int quota);
      int                sent;
      int unsigned       kind;
      int unsigned       len;
      logic [CHAR_W-1:0] ch;
      sent = 0;
      while (sent < quota) begin
         kind = $urandom_range(0, 9);
         if (kind <= 4) begin
            // A line of text, now and then long enough to wrap at the last column.
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 20);
            repeat (len) begin
               if ($urandom_range(0, 19) == 0) ch = CHAR_W'($urandom_range(0, 255));
               else ch = CHAR_W'($urandom_range(PRINT_LO, PRINT_HI));
               put_char(ch);
               if (ch != CHAR_NUL) sent++;
            end
            if ($urandom_range(0, 4) != 0) begin
               put_char(CHAR_NEWLINE);
               sent++;
            end
         end else if (kind <= 7) begin
            repeat ($urandom_range(1, 6)) begin
               read_random();
               sent++;
            end
         end else if (kind == 8) begin
            repeat ($urandom_range(1, 4)) begin
               ch = CHAR_W'($urandom_range(0, 255));
               put_char(ch);
               if (ch != CHAR_NUL) sent++;
            end
         end else begin
            repeat ($urandom_range(1, 3)) begin
               put_char(CHAR_NEWLINE);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      // The store is cleared after reset; wait until the block reports idle.
      drain();

      idle_pct = 16;
      set_colors(FG_COLOR_RESET, 1'b0, BG_COLOR_RESET, 1'b0);
      read_cell(5'd0, 7'd0);
      read_cell(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
      read_cell(ROW_W'(ROWS), 7'd0);
      read_cell(5'd0, COL_W'(COLUMNS));
      read_cell(5'd31, 7'd127);
      put_char(CHAR_NUL);
      put_char(PRINT_LO);
      put_char(PRINT_HI);
      put_char(8'd65);
      put_char(8'd127);
      put_char(8'd255);
      put_char(8'd31);
      put_char(8'd1);
      put_char(CHAR_NEWLINE);
      put_char(8'd128);
      read_cell(5'd0, 7'd0);
      read_cell(5'd0, 7'd1);
      read_cell(5'd0, 7'd2);
      read_cell(5'd0, 7'd3);
      read_cell(5'd0, 7'd4);
      read_cell(5'd1, 7'd0);
      random_phase(132);

      drain();
      idle_pct = 84;
      set_colors(3'd0, 1'b0, 3'd0, 1'b0);
      random_phase(132);

      drain();
      idle_pct = 0;
      set_colors(3'd7, 1'b1, 3'd7, 1'b1);
      random_phase(132);

      drain();
      set_colors(COLOR_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 COLOR_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      random_phase(132);

      drain();
      repeat (10) @(posedge clock);
      if (shadow.errors == 0 && shadow.awaited.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
